// File: src/frmon_pkg.sv
// Shared types, codes and constants for the frame interval rate monitor.
package frmon_pkg;

	// Default ring depth and the fixed field widths
	localparam int RING_DEPTH_DEF = 256;
	localparam int WIN_W          = 9;
	localparam int TS_W           = 64;
	localparam int RATE_W         = 32;

	// Window length after reset
	localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd240;

	// Nanoseconds per second, narrow enough for a small multiplier
	localparam int NS_W = 30;
	localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

	// Fraction bits of the 16.16 rate
	localparam int FRAC_W = 16;

	// Restoring divider: one quotient bit per cycle
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 5;

	// Request function codes
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic push;
		logic start_query;
		logic mul;
		logic prep;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic walk_done;
		logic div_done;
	} sts_t;

endpackage

// File: src/frame_interval_rate_monitor.sv
// The walk reads one ring slot per cycle; a restoring divider follows.
// A push gives no result; one request is worked at a time.
// A finished result waits in the output register while a push is accepted.
// Reset clears the window to 240 and empties the ring; ring contents stay unset.
// Top level: frame interval rate monitor.
module frame_interval_rate_monitor #(
	parameter int RING_DEPTH = frmon_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [frmon_pkg::WIN_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [frmon_pkg::TS_W-1:0]        timestamp_ns,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              rate_valid,
	output logic [frmon_pkg::RATE_W-1:0]      rate_fps_q16,
	output logic [frmon_pkg::TS_W-1:0]        best_interval_ns,
	output logic [frmon_pkg::TS_W-1:0]        worst_interval_ns
);

	frmon_pkg::cmd_t cmd;
	frmon_pkg::sts_t sts;

	// Controller
	frmon_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath
	frmon_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.timestamp_ns      (timestamp_ns),
		.rate_valid        (rate_valid),
		.rate_fps_q16      (rate_fps_q16),
		.best_interval_ns  (best_interval_ns),
		.worst_interval_ns (worst_interval_ns)
	);

	// A push never raises a result
	a_push_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == frmon_pkg::FUNC_PUSH && !out_valid |=> !out_valid)
		else $error("result raised by a push");

	// A query holds off further requests
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == frmon_pkg::FUNC_QUERY |=> in_stall)
		else $error("request taken while a query runs");

	// No rate without counted intervals
	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rate_valid |-> rate_fps_q16 == '0)
		else $error("rate nonzero on an invalid result");

	// Best interval never exceeds worst
	a_best_worst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_interval_ns <= worst_interval_ns)
		else $error("best interval above worst");

endmodule

// File: src/frmon_ctrl.sv
// Controller state machine: request handshake, query sequencing, result slot.
module frmon_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              func,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output frmon_pkg::cmd_t   cmd,
	input  frmon_pkg::sts_t   sts
);

	frmon_pkg::state_t state_q, state_d;
	logic out_full_q;
	logic slot_free;

	// Result slot is free when empty or being taken this cycle
	assign slot_free = !out_full_q || !out_stall;
	assign out_valid = out_full_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frmon_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			frmon_pkg::ST_IDLE: begin
				if (in_valid && func == frmon_pkg::FUNC_QUERY) begin
					state_d = frmon_pkg::ST_WALK;
				end
			end
			frmon_pkg::ST_WALK: begin
				if (sts.walk_done) begin
					state_d = frmon_pkg::ST_MUL;
				end
			end
			frmon_pkg::ST_MUL:  state_d = frmon_pkg::ST_PREP;
			frmon_pkg::ST_PREP: state_d = frmon_pkg::ST_DIV;
			frmon_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = frmon_pkg::ST_DONE;
				end
			end
			frmon_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = frmon_pkg::ST_IDLE;
				end
			end
			default: state_d = frmon_pkg::ST_IDLE;
		endcase
	end

	// Outputs and commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			frmon_pkg::ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.push        = in_valid && func == frmon_pkg::FUNC_PUSH;
				cmd.start_query = in_valid && func == frmon_pkg::FUNC_QUERY;
			end
			frmon_pkg::ST_MUL:  cmd.mul      = 1'b1;
			frmon_pkg::ST_PREP: cmd.prep     = 1'b1;
			frmon_pkg::ST_DIV:  cmd.div_step = 1'b1;
			frmon_pkg::ST_DONE: cmd.load_out = slot_free;
			default: ;
		endcase
	end

	// Result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (!out_stall) begin
			out_full_q <= 1'b0;
		end
	end

endmodule

// File: src/frmon_dp.sv
// Datapath: timestamp ring, interval walk, rate multiply and divide, result registers.
module frmon_dp #(
	parameter int RING_DEPTH = frmon_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frmon_pkg::cmd_t                   cmd,
	output frmon_pkg::sts_t                   sts,
	input  logic                              cfg_we,
	input  logic [frmon_pkg::WIN_W-1:0]       cfg_wdata,
	input  logic [frmon_pkg::TS_W-1:0]        timestamp_ns,
	output logic                              rate_valid,
	output logic [frmon_pkg::RATE_W-1:0]      rate_fps_q16,
	output logic [frmon_pkg::TS_W-1:0]        best_interval_ns,
	output logic [frmon_pkg::TS_W-1:0]        worst_interval_ns
);

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int WIDE_W = (CNT_W > frmon_pkg::WIN_W) ? CNT_W : frmon_pkg::WIN_W;
	localparam int SUM_W  = frmon_pkg::TS_W + CNT_W;
	localparam int PROD_W = frmon_pkg::NS_W + CNT_W;
	localparam int TS_W   = frmon_pkg::TS_W;
	localparam int HALF_W = TS_W / 2;

	// Configuration and ring bookkeeping
	logic [frmon_pkg::WIN_W-1:0] window_q;
	logic [IDX_W-1:0]            write_pos_q;
	logic [CNT_W-1:0]            stored_count_q;
	logic [CNT_W-1:0]            cap;
	logic [WIDE_W-1:0]           win_ext;
	logic [IDX_W-1:0]            pos_eff;
	logic [CNT_W-1:0]            pos_next;

	// Ring memory and read port
	logic [TS_W-1:0]  ring [RING_DEPTH];
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic [TS_W-1:0]  rd_data_s1;

	// Walk control
	logic             walk_act_q;
	logic             issue_act_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic             issue_last;
	logic             tag_vld_s1;
	logic             tag_prime_s1;
	logic             tag_last_s1;
	logic [TS_W-1:0]  prev_q;
	logic [TS_W-1:0]  diff_s2;
	logic             ok_s2;
	logic             fin_s2;

	// Accumulators
	logic [TS_W-1:0]  best_q;
	logic [TS_W-1:0]  worst_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	// Rate arithmetic
	logic [PROD_W-1:0]               prod;
	logic [TS_W-1:0]                 num_q;
	logic                            sat_q;
	logic [TS_W-1:0]                 rem_q;
	logic [HALF_W-1:0]               quo_q;
	logic [frmon_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [TS_W:0]                   trial;
	logic [TS_W:0]                   divisor;
	logic                            trial_ge;
	logic                            stats_ok;

	// Effective window: zero counts as one, capped at the ring depth
	always_comb begin
		win_ext = WIDE_W'(window_q);
		if (window_q == '0) begin
			cap = CNT_W'(1);
		end else if (win_ext > WIDE_W'(RING_DEPTH)) begin
			cap = CNT_W'(RING_DEPTH);
		end else begin
			cap = CNT_W'(win_ext);
		end
	end

	// Write position after wrap
	always_comb begin
		pos_eff  = (CNT_W'(write_pos_q) >= cap) ? '0 : write_pos_q;
		pos_next = CNT_W'(pos_eff) + CNT_W'(1);
	end

	// Window register, write position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= frmon_pkg::WINDOW_RESET;
			write_pos_q    <= '0;
			stored_count_q <= '0;
		end else if (cfg_we) begin
			window_q       <= cfg_wdata;
			write_pos_q    <= '0;
			stored_count_q <= '0;
		end else if (cmd.push) begin
			write_pos_q <= (pos_next >= cap) ? '0 : pos_next[IDX_W-1:0];
			if (stored_count_q < cap) begin
				stored_count_q <= stored_count_q + CNT_W'(1);
			end
		end
	end

	// Ring write
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring[pos_eff] <= timestamp_ns;
		end
	end

	// Read address: highest filled slot first, then slots upward from zero
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = idx_q[IDX_W-1:0];
		issue_last = (idx_q == n_q - CNT_W'(1));
		if (cmd.start_query) begin
			rd_en   = stored_count_q != '0;
			rd_addr = IDX_W'(stored_count_q - CNT_W'(1));
		end else if (issue_act_q) begin
			rd_en = 1'b1;
		end
	end

	// Ring read, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= ring[rd_addr];
		end
	end

	// Walk sequencing and pair check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_act_q   <= 1'b0;
			issue_act_q  <= 1'b0;
			idx_q        <= '0;
			n_q          <= '0;
			tag_vld_s1   <= 1'b0;
			tag_prime_s1 <= 1'b0;
			tag_last_s1  <= 1'b0;
			ok_s2        <= 1'b0;
			fin_s2       <= 1'b0;
		end else begin
			tag_vld_s1   <= 1'b0;
			tag_prime_s1 <= 1'b0;
			tag_last_s1  <= 1'b0;
			ok_s2        <= 1'b0;
			fin_s2       <= 1'b0;
			if (cmd.start_query) begin
				n_q   <= stored_count_q;
				idx_q <= '0;
				if (stored_count_q == '0) begin
					fin_s2 <= 1'b1;
				end else begin
					walk_act_q   <= 1'b1;
					issue_act_q  <= 1'b1;
					tag_vld_s1   <= 1'b1;
					tag_prime_s1 <= 1'b1;
				end
			end else begin
				// issue the next slot read
				if (issue_act_q) begin
					tag_vld_s1  <= 1'b1;
					tag_last_s1 <= issue_last;
					idx_q       <= idx_q + CNT_W'(1);
					if (issue_last) begin
						issue_act_q <= 1'b0;
					end
				end
				// process the slot that came back
				if (tag_vld_s1 && walk_act_q && !tag_prime_s1) begin
					if (rd_data_s1 == '0) begin
						fin_s2      <= 1'b1;
						walk_act_q  <= 1'b0;
						issue_act_q <= 1'b0;
					end else begin
						ok_s2  <= (prev_q != '0) && (prev_q < rd_data_s1);
						fin_s2 <= tag_last_s1;
						if (tag_last_s1) begin
							walk_act_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Previous stamp and interval
	always_ff @(posedge clk) begin
		if (tag_vld_s1 && walk_act_q) begin
			prev_q  <= rd_data_s1;
			diff_s2 <= rd_data_s1 - prev_q;
		end
	end

	// Best, worst, sum and count of counted intervals
	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			best_q  <= '0;
			worst_q <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else if (ok_s2) begin
			if (best_q == '0 || diff_s2 < best_q) begin
				best_q <= diff_s2;
			end
			if (diff_s2 > worst_q) begin
				worst_q <= diff_s2;
			end
			sum_q <= sum_q + SUM_W'(diff_s2);
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Numerator 1e9 * count, put in 16.16 by the shift in the multiply step
	assign prod = PROD_W'(frmon_pkg::NS_PER_SEC) * PROD_W'(cnt_q);

	// Divider step: shift in one numerator bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quo_q[HALF_W-1]};
		divisor  = {1'b0, sum_q[TS_W-1:0]};
		trial_ge = trial >= divisor;
	end

	// Multiply, saturation check and restoring division
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q <= TS_W'(prod) << frmon_pkg::FRAC_W;
		end
		if (cmd.prep) begin
			// quotient above 32 bits exactly when the high half reaches the divisor
			sat_q     <= TS_W'(num_q[TS_W-1:HALF_W]) >= sum_q[TS_W-1:0];
			rem_q     <= TS_W'(num_q[TS_W-1:HALF_W]);
			quo_q     <= num_q[HALF_W-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? TS_W'(trial - divisor) : trial[TS_W-1:0];
			quo_q     <= {quo_q[HALF_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + frmon_pkg::DIV_CNT_W'(1);
		end
	end

	// Status back to the controller
	always_comb begin
		sts.walk_done = fin_s2;
		sts.div_done  = cmd.div_step &&
			(div_cnt_q == frmon_pkg::DIV_CNT_W'(frmon_pkg::DIV_STEPS - 1));
	end

	assign stats_ok = (cnt_q != '0) && (sum_q != '0);

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rate_valid        <= stats_ok;
			best_interval_ns  <= best_q;
			worst_interval_ns <= worst_q;
			if (!stats_ok || sum_q[SUM_W-1:TS_W] != '0) begin
				rate_fps_q16 <= '0;
			end else if (sat_q) begin
				rate_fps_q16 <= '1;
			end else begin
				rate_fps_q16 <= quo_q;
			end
		end
	end

endmodule
